[rtl/rau_pkg.sv]
// rational arithmetic unit package
// function, error, multiplier and divider codes, controller/datapath structs
`timescale 1ns / 1ps

package rau_pkg;

   localparam logic [2:0] FUNC_ADD  = 3'd0;
   localparam logic [2:0] FUNC_MUL  = 3'd1;
   localparam logic [2:0] FUNC_DIV  = 3'd2;
   localparam logic [2:0] FUNC_LT   = 3'd3;
   localparam logic [2:0] FUNC_LE   = 3'd4;
   localparam logic [2:0] FUNC_GT   = 3'd5;
   localparam logic [2:0] FUNC_GE   = 3'd6;
   localparam logic [2:0] FUNC_NONE = 3'd7;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_ZDEN = 2'd1;
   localparam logic [1:0] ERR_DIVZ = 2'd2;
   localparam logic [1:0] ERR_OVF  = 2'd3;

   localparam logic [2:0] MUL_AN_BD  = 3'd0;
   localparam logic [2:0] MUL_AD_BN  = 3'd1;
   localparam logic [2:0] MUL_AD_BD  = 3'd2;
   localparam logic [2:0] MUL_AN_BN  = 3'd3;
   localparam logic [2:0] MUL_NLO_SC = 3'd4;
   localparam logic [2:0] MUL_NHI_SC = 3'd5;

   localparam logic [2:0] DIV_GCD = 3'd0;
   localparam logic [2:0] DIV_N   = 3'd1;
   localparam logic [2:0] DIV_D   = 3'd2;
   localparam logic [2:0] DIV_Q   = 3'd3;
   localparam logic [2:0] DIV_MD  = 3'd4;

   localparam int DIVIDEND_W = 96;
   localparam int DIVISOR_W  = 64;

   localparam logic [63:0] FULL_LIMIT = 64'd2147483647;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       comb;
      logic       gcd_init;
      logic       div_start;
      logic [2:0] div_op;
      logic       res_zero;
      logic       res_frac;
      logic       res_cmp;
      logic       res_appr;
      logic [1:0] res_err;
      logic       emit;
   } rau_cmd_type;

   typedef struct packed {
      logic       early;
      logic [1:0] early_err;
      logic       is_cmp;
      logic       n_zero;
      logic       gx_zero;
      logic       fits;
      logic       ovf;
      logic       div_done;
      logic       div_busy;
      logic       approx;
   } rau_status_type;

endpackage

[rtl/rational_arith_unit_top.sv]
// Exact arithmetic on two signed 32-bit fractions: add, multiply, divide or
// compare, with gcd reduction and decimal approximation when a reduced result
// reaches the 32-bit limit. One word is processed at a time. An early error or
// a comparison finishes without the divider; otherwise each reduction runs one
// division per euclid step plus two more, and approximation adds two more
// divisions, two multiplies and a second reduction; the time is set by the
// single shared 96-step bit-serial divider. A new word is taken while a finished
// result still waits in the output register.
// depends on rau_pkg, rau_ctrl, rau_dp
`timescale 1ns / 1ps

module rational_arith_unit_top
   import rau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_cmp_true,
   output logic               rsp_approximated,
   output logic [1:0]         rsp_error
);

   rau_cmd_type    cmd;
   rau_status_type status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rau_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_a_num        (req_a_num),
      .req_a_den        (req_a_den),
      .req_b_num        (req_b_num),
      .req_b_den        (req_b_den),
      .rsp_res_num      (rsp_res_num),
      .rsp_res_den      (rsp_res_den),
      .rsp_cmp_true     (rsp_cmp_true),
      .rsp_approximated (rsp_approximated),
      .rsp_error        (rsp_error)
   );

endmodule

[rtl/rau_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on rau_pkg for operand widths
`timescale 1ns / 1ps

module rau_div
   import rau_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quot,
   output logic [DIVISOR_W-1:0]  rem
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

[rtl/rau_dp.sv]
// datapath: operand registers, shared multiplier, gcd registers, result words
// depends on rau_pkg and rau_div
`timescale 1ns / 1ps

module rau_dp
   import rau_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  rau_cmd_type           cmd,
   output rau_status_type        status,
   input  logic [2:0]            req_func,
   input  logic signed [31:0]    req_a_num,
   input  logic signed [31:0]    req_a_den,
   input  logic signed [31:0]    req_b_num,
   input  logic signed [31:0]    req_b_den,
   output logic signed [31:0]    rsp_res_num,
   output logic [30:0]           rsp_res_den,
   output logic                  rsp_cmp_true,
   output logic                  rsp_approximated,
   output logic [1:0]            rsp_error
);

   logic [2:0]  func_ff;
   logic [31:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic        ans_ff, ads_ff, bns_ff, bds_ff;
   logic [63:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic [63:0] n_ff, d_ff, gx_ff, gy_ff, q_ff;
   logic        neg_ff, approx_ff;
   logic [2:0]  op_ff;
   logic signed [31:0] st_num_ff, out_num_ff;
   logic [30:0] st_den_ff, out_den_ff;
   logic        st_cmp_ff, out_cmp_ff, st_appr_ff, out_appr_ff;
   logic [1:0]  st_err_ff, out_err_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [19:0] scale;
   logic [DIVIDEND_W-1:0] dvd;
   logic [DIVISOR_W-1:0]  dvs;
   logic [DIVIDEND_W-1:0] quot;
   logic [DIVISOR_W-1:0]  rem;
   logic        div_busy, div_done;
   logic        s1, s2, flip;
   logic [63:0] nm, dm;
   logic        nneg, dneg;
   logic signed [64:0] lhs, rhs;
   logic        cmp_res;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_AN_BD:  begin mul_a = an_ff;        mul_b = bd_ff;           end
         MUL_AD_BN:  begin mul_a = ad_ff;        mul_b = bn_ff;           end
         MUL_AD_BD:  begin mul_a = ad_ff;        mul_b = bd_ff;           end
         MUL_AN_BN:  begin mul_a = an_ff;        mul_b = bn_ff;           end
         MUL_NLO_SC: begin mul_a = n_ff[31:0];   mul_b = {12'd0, scale};  end
         MUL_NHI_SC: begin mul_a = n_ff[63:32];  mul_b = {12'd0, scale};  end
         default:    begin mul_a = '0;           mul_b = '0;              end
      endcase
   end
   assign prod = mul_a * mul_b;

   // decimal scale from quotient magnitude
   always_comb begin
      if (q_ff < 64'd100)            scale = 20'd1000000;
      else if (q_ff < 64'd1000)      scale = 20'd100000;
      else if (q_ff < 64'd100000)    scale = 20'd10000;
      else if (q_ff < 64'd1000000)   scale = 20'd1000;
      else if (q_ff < 64'd10000000)  scale = 20'd100;
      else if (q_ff < 64'd100000000) scale = 20'd10;
      else                           scale = 20'd1;
   end

   // divider operand select
   always_comb begin
      case (cmd.div_op)
         DIV_GCD: begin dvd = {32'd0, gy_ff}; dvs = gx_ff; end
         DIV_N:   begin dvd = {32'd0, n_ff};  dvs = gy_ff; end
         DIV_D:   begin dvd = {32'd0, d_ff};  dvs = gy_ff; end
         DIV_Q:   begin dvd = {32'd0, n_ff};  dvs = d_ff;  end
         DIV_MD:  begin dvd = {32'd0, m1_ff} + {m2_ff, 32'd0}; dvs = d_ff; end
         default: begin dvd = '0; dvs = '0; end
      endcase
   end

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   // combine cross products
   always_comb begin
      s1   = ans_ff ^ bds_ff;
      s2   = ads_ff ^ bns_ff;
      flip = ads_ff ^ bds_ff;
      nm   = m4_ff;
      nneg = ans_ff ^ bns_ff;
      dm   = m3_ff;
      dneg = flip;
      case (func_ff)
         FUNC_ADD: begin
            if (s1 == s2) begin
               nm = m1_ff + m2_ff; nneg = s1;
            end else if (m1_ff >= m2_ff) begin
               nm = m1_ff - m2_ff; nneg = s1;
            end else begin
               nm = m2_ff - m1_ff; nneg = s2;
            end
         end
         FUNC_DIV: begin
            nm = m1_ff; nneg = s1;
            dm = m2_ff; dneg = s2;
         end
         default: ;
      endcase
      lhs = (s1 ^ flip) ? -$signed({1'b0, m1_ff}) : $signed({1'b0, m1_ff});
      rhs = (s2 ^ flip) ? -$signed({1'b0, m2_ff}) : $signed({1'b0, m2_ff});
      case (func_ff)
         FUNC_LT: cmp_res = lhs < rhs;
         FUNC_LE: cmp_res = lhs <= rhs;
         FUNC_GT: cmp_res = lhs > rhs;
         FUNC_GE: cmp_res = lhs >= rhs;
         default: cmp_res = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         an_ff   <= mag32(req_a_num);
         ad_ff   <= mag32(req_a_den);
         bn_ff   <= mag32(req_b_num);
         bd_ff   <= mag32(req_b_den);
         ans_ff  <= req_a_num[31];
         ads_ff  <= req_a_den[31];
         bns_ff  <= req_b_num[31];
         bds_ff  <= req_b_den[31];
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_AN_BD, MUL_NLO_SC: m1_ff <= prod;
            MUL_AD_BN, MUL_NHI_SC: m2_ff <= prod;
            MUL_AD_BD:             m3_ff <= prod;
            MUL_AN_BN:             m4_ff <= prod;
            default: ;
         endcase
      end
      if (cmd.comb) begin
         n_ff   <= nm;
         d_ff   <= dm;
         neg_ff <= nneg ^ dneg;
      end
      if (cmd.gcd_init) begin
         gx_ff <= n_ff;
         gy_ff <= d_ff;
      end
      if (cmd.div_start) op_ff <= cmd.div_op;
      if (div_done) begin
         case (op_ff)
            DIV_GCD: begin gy_ff <= gx_ff; gx_ff <= rem; end
            DIV_N:   n_ff <= quot[63:0];
            DIV_D:   d_ff <= quot[63:0];
            DIV_Q:   q_ff <= quot[63:0];
            DIV_MD:  begin n_ff <= quot[63:0]; d_ff <= {44'd0, scale}; end
            default: ;
         endcase
      end
      if (cmd.res_zero) begin
         st_num_ff  <= '0;
         st_den_ff  <= 31'd1;
         st_cmp_ff  <= 1'b0;
         st_appr_ff <= cmd.res_appr;
         st_err_ff  <= cmd.res_err;
      end
      if (cmd.res_cmp) begin
         st_num_ff  <= '0;
         st_den_ff  <= 31'd1;
         st_cmp_ff  <= cmp_res;
         st_appr_ff <= 1'b0;
         st_err_ff  <= ERR_NONE;
      end
      if (cmd.res_frac) begin
         st_num_ff  <= neg_ff ? (32'sd0 - $signed(n_ff[31:0])) : $signed(n_ff[31:0]);
         st_den_ff  <= d_ff[30:0];
         st_cmp_ff  <= 1'b0;
         st_appr_ff <= approx_ff;
         st_err_ff  <= ERR_NONE;
      end
      if (cmd.emit) begin
         out_num_ff  <= st_num_ff;
         out_den_ff  <= st_den_ff;
         out_cmp_ff  <= st_cmp_ff;
         out_appr_ff <= st_appr_ff;
         out_err_ff  <= st_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         approx_ff <= 1'b0;
      end else if (cmd.load) begin
         approx_ff <= 1'b0;
      end else if (div_done && op_ff == DIV_MD) begin
         approx_ff <= 1'b1;
      end
   end

   always_comb begin
      status.early_err = ERR_NONE;
      if (func_ff == FUNC_NONE)          status.early_err = ERR_NONE;
      else if (ad_ff == '0 || bd_ff == '0) status.early_err = ERR_ZDEN;
      else if (func_ff == FUNC_DIV && bn_ff == '0) status.early_err = ERR_DIVZ;
      status.early    = (func_ff == FUNC_NONE) || (status.early_err != ERR_NONE);
      status.is_cmp   = func_ff >= FUNC_LT;
      status.n_zero   = n_ff == '0;
      status.gx_zero  = gx_ff == '0;
      status.fits     = (n_ff < FULL_LIMIT) && (d_ff < FULL_LIMIT);
      status.ovf      = q_ff >= FULL_LIMIT;
      status.div_done = div_done;
      status.div_busy = div_busy;
      status.approx   = approx_ff;
   end

   assign rsp_res_num      = out_num_ff;
   assign rsp_res_den      = out_den_ff;
   assign rsp_cmp_true     = out_cmp_ff;
   assign rsp_approximated = out_appr_ff;
   assign rsp_error        = out_err_ff;

endmodule

[rtl/rau_ctrl.sv]
// controller state machine: sequences multiplies, gcd steps and divisions
// depends on rau_pkg; drives rau_dp through command and status structs
`timescale 1ns / 1ps

module rau_ctrl
   import rau_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  rau_status_type status,
   output rau_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLASS  = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_COMB   = 4'd3;
   localparam logic [3:0] S_CHK0   = 4'd4;
   localparam logic [3:0] S_GCD    = 4'd5;
   localparam logic [3:0] S_GWAIT  = 4'd6;
   localparam logic [3:0] S_NWAIT  = 4'd7;
   localparam logic [3:0] S_DWAIT  = 4'd8;
   localparam logic [3:0] S_CHECK  = 4'd9;
   localparam logic [3:0] S_QWAIT  = 4'd10;
   localparam logic [3:0] S_SCALE  = 4'd11;
   localparam logic [3:0] S_PHI    = 4'd12;
   localparam logic [3:0] S_MDST   = 4'd13;
   localparam logic [3:0] S_MDWAIT = 4'd14;
   localparam logic [3:0] S_FIN    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            cnt_in = '0;
            if (status.early) begin
               cmd.res_zero = 1'b1;
               cmd.res_err  = status.early_err;
               state_in     = S_FIN;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = {1'b0, cnt_ff};
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) state_in = S_COMB;
         end
         S_COMB: begin
            if (status.is_cmp) begin
               cmd.res_cmp = 1'b1;
               state_in    = S_FIN;
            end else begin
               cmd.comb = 1'b1;
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            if (status.n_zero) begin
               cmd.res_zero = 1'b1;
               cmd.res_appr = status.approx;
               cmd.res_err  = ERR_NONE;
               state_in     = S_FIN;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = S_GCD;
            end
         end
         S_GCD: begin
            cmd.div_start = 1'b1;
            if (status.gx_zero) begin
               cmd.div_op = DIV_N;
               state_in   = S_NWAIT;
            end else begin
               cmd.div_op = DIV_GCD;
               state_in   = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (status.div_done) state_in = S_GCD;
         end
         S_NWAIT: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_D;
               state_in      = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (status.div_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.approx || status.fits) begin
               cmd.res_frac = 1'b1;
               state_in     = S_FIN;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_Q;
               state_in      = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (status.div_done) state_in = S_SCALE;
         end
         S_SCALE: begin
            if (status.ovf) begin
               cmd.res_zero = 1'b1;
               cmd.res_appr = 1'b1;
               cmd.res_err  = ERR_OVF;
               state_in     = S_FIN;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_NLO_SC;
               state_in    = S_PHI;
            end
         end
         S_PHI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NHI_SC;
            state_in    = S_MDST;
         end
         S_MDST: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MD;
            state_in      = S_MDWAIT;
         end
         S_MDWAIT: begin
            if (status.div_done) state_in = S_CHK0;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)          rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && status.div_busy))
      else $error("divider started while busy");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result word overwritten before taken");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted word not presented");
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_GWAIT || state_ff == S_NWAIT ||
                           state_ff == S_DWAIT || state_ff == S_QWAIT ||
                           state_ff == S_MDWAIT))
      else $error("divider finished outside a wait state");
`endif

endmodule
